// ===== sv/uas_pkg.sv =====
// Shared types and constants for the upwind advection stencil.
// No dependencies; imported by every module of the block.
package uas_pkg;

  localparam int DATA_W = 32;                // Q16.16 scalars and velocities
  localparam int U_W    = DATA_W + 1;        // free-stream plus cell velocity
  localparam int D_W    = DATA_W + 4;        // one-sided difference, |d| < 12*2^31
  localparam int P_W    = U_W + D_W;         // u*d, exact
  localparam int SUM_W  = P_W + 1;           // sum of both axes
  localparam int HALF_W = SUM_W / 2;         // split of the sum for the scale multiply
  localparam int LO_W   = HALF_W + 1 + DATA_W;
  localparam int HI_W   = SUM_W - HALF_W + DATA_W;
  localparam int FULL_W = SUM_W + DATA_W;    // exact scaled product
  localparam int FRAC_W = 32;                // Q32.32 * Q16.16 -> Q16.16 shift

  localparam logic [1:0] EDGE_INTERIOR = 2'd0;
  localparam logic [1:0] EDGE_LEFT     = 2'd1;
  localparam logic [1:0] EDGE_RIGHT    = 2'd2;

  localparam logic [1:0] REG_FREESTREAM_X = 2'd0;
  localparam logic [1:0] REG_FREESTREAM_Y = 2'd1;
  localparam logic [1:0] REG_SCALE_FACTOR = 2'd2;

  // classified cell: advecting velocity and the upwind difference per axis
  typedef struct packed {
    logic signed [U_W-1:0] ux;
    logic signed [D_W-1:0] dx;
    logic signed [U_W-1:0] uy;
    logic signed [D_W-1:0] dy;
  } uas_item_t;

endpackage

// ===== sv/uas_front.sv =====
// Front end: accepts cells, applies the edge code, forms the velocities
// and picks the upwind difference per axis. Depends on uas_pkg.
module uas_front import uas_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] w_center,
  input  logic signed [DATA_W-1:0] w_left2,
  input  logic signed [DATA_W-1:0] w_left1,
  input  logic signed [DATA_W-1:0] w_right1,
  input  logic signed [DATA_W-1:0] w_right2,
  input  logic signed [DATA_W-1:0] w_down2,
  input  logic signed [DATA_W-1:0] w_down1,
  input  logic signed [DATA_W-1:0] w_up1,
  input  logic signed [DATA_W-1:0] w_up2,
  input  logic signed [DATA_W-1:0] vel_x,
  input  logic signed [DATA_W-1:0] vel_y,
  input  logic [1:0]               edge_case,
  input  logic signed [DATA_W-1:0] freestream_x,
  input  logic signed [DATA_W-1:0] freestream_y,
  output logic                     item_valid,
  output uas_item_t                item,
  input  logic                     item_ready
);

  // dA = 2*p1 + 3*c - 6*m1 + m2
  function automatic logic signed [D_W-1:0] diff_a(
    input logic signed [D_W-1:0] m2, input logic signed [D_W-1:0] m1,
    input logic signed [D_W-1:0] c,  input logic signed [D_W-1:0] p1);
    diff_a = (p1 <<< 1) + (c <<< 1) + c - (m1 <<< 2) - (m1 <<< 1) + m2;
  endfunction

  // dB = -p2 + 6*p1 - 3*c - 2*m1
  function automatic logic signed [D_W-1:0] diff_b(
    input logic signed [D_W-1:0] m1, input logic signed [D_W-1:0] c,
    input logic signed [D_W-1:0] p1, input logic signed [D_W-1:0] p2);
    diff_b = (p1 <<< 2) + (p1 <<< 1) - p2 - (c <<< 1) - c - (m1 <<< 1);
  endfunction

  logic signed [D_W-1:0] c_e, l2_e, l1_e, r1_e, r2_e, d2_e, d1_e, u1_e, u2_e;
  logic signed [U_W-1:0] ux, uy;
  logic signed [D_W-1:0] dax, dbx, day, dby;
  logic                  zero_left, zero_right;
  uas_item_t             item_next;

  // unused edge code behaves as an interior cell
  assign zero_left  = (edge_case == EDGE_LEFT);
  assign zero_right = (edge_case == EDGE_RIGHT);

  always_comb begin
    c_e  = D_W'(w_center);
    l2_e = zero_left  ? '0 : D_W'(w_left2);
    l1_e = zero_left  ? '0 : D_W'(w_left1);
    r1_e = zero_right ? '0 : D_W'(w_right1);
    r2_e = zero_right ? '0 : D_W'(w_right2);
    d2_e = D_W'(w_down2);
    d1_e = D_W'(w_down1);
    u1_e = D_W'(w_up1);
    u2_e = D_W'(w_up2);

    ux = U_W'(freestream_x) + U_W'(vel_x);
    uy = U_W'(freestream_y) + U_W'(vel_y);

    dax = diff_a(l2_e, l1_e, c_e, r1_e);
    dbx = diff_b(l1_e, c_e, r1_e, r2_e);
    day = diff_a(d2_e, d1_e, c_e, u1_e);
    dby = diff_b(d1_e, c_e, u1_e, u2_e);

    // u == 0 takes dB; the product is zero either way
    item_next.ux = ux;
    item_next.dx = (!ux[U_W-1] && (ux != '0)) ? dax : dbx;
    item_next.uy = uy;
    item_next.dy = (!uy[U_W-1] && (uy != '0)) ? day : dby;
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

// ===== sv/uas_queue.sv =====
// Short FIFO between the front end and the multiply pipeline.
// Depends on uas_pkg for the item type.
module uas_queue import uas_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  uas_item_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output uas_item_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  uas_item_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== sv/uas_back.sv =====
// Back end: velocity products, axis sum, split scale multiply, shift and
// saturate into the output register. Depends on uas_pkg.
module uas_back import uas_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  uas_item_t                item,
  input  logic signed [DATA_W-1:0] scale_factor,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] rhs_value
);

  logic                    v1, v2, v3;
  logic                    en1, en2, en3, en_o;
  logic signed [P_W-1:0]   px, py;
  logic signed [SUM_W-1:0] sum;
  logic signed [LO_W-1:0]  prod_lo;
  logic signed [HI_W-1:0]  prod_hi;
  logic signed [FULL_W-1:0]         full;
  logic signed [FULL_W-FRAC_W-1:0]  shifted;
  logic signed [DATA_W-1:0]         rhs_next;
  logic                             fits;

  assign en_o       = !out_valid || out_ready;
  assign en3        = !v3 || en_o;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= item_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en_o) out_valid <= v3;
    end
  end

  // low half of the sum is unsigned, high half carries the sign
  always_comb begin
    full     = (FULL_W'(prod_hi) <<< HALF_W) + FULL_W'(prod_lo);
    shifted  = full[FULL_W-1:FRAC_W];
    fits     = (shifted[FULL_W-FRAC_W-1:DATA_W-1] == '0) ||
               (shifted[FULL_W-FRAC_W-1:DATA_W-1] == '1);
    if (fits) begin
      rhs_next = shifted[DATA_W-1:0];
    end else if (shifted[FULL_W-FRAC_W-1]) begin
      rhs_next = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      rhs_next = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && item_valid) begin
      px <= item.ux * item.dx;
      py <= item.uy * item.dy;
    end
    if (en2 && v1) begin
      sum <= SUM_W'(px) + SUM_W'(py);
    end
    if (en3 && v2) begin
      prod_lo <= $signed({1'b0, sum[HALF_W-1:0]}) * scale_factor;
      prod_hi <= $signed(sum[SUM_W-1:HALF_W]) * scale_factor;
    end
    if (en_o && v3) begin
      rhs_value <= rhs_next;
    end
  end

endmodule

// ===== sv/upwind_advection_stencil.sv =====
// Third-order upwind advection stencil, one cell per transaction.
// Path from input acceptance to rhs_value valid: front register, queue,
// product, sum and scale multiply registers, then the output register.
// Throughput: one cell per cycle while out_ready is high (pipelined back end).
// Reset (rst, synchronous): clears all valid state and the three registers.
// Depends on uas_pkg, uas_front, uas_queue, uas_back.
module upwind_advection_stencil import uas_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] w_center,
  input  logic signed [DATA_W-1:0] w_left2,
  input  logic signed [DATA_W-1:0] w_left1,
  input  logic signed [DATA_W-1:0] w_right1,
  input  logic signed [DATA_W-1:0] w_right2,
  input  logic signed [DATA_W-1:0] w_down2,
  input  logic signed [DATA_W-1:0] w_down1,
  input  logic signed [DATA_W-1:0] w_up1,
  input  logic signed [DATA_W-1:0] w_up2,
  input  logic signed [DATA_W-1:0] vel_x,
  input  logic signed [DATA_W-1:0] vel_y,
  input  logic [1:0]               edge_case,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] rhs_value
);

  logic signed [DATA_W-1:0] freestream_x, freestream_y, scale_factor;
  logic      fq_valid, fq_ready, qb_valid, qb_ready;
  uas_item_t fq_item, qb_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      freestream_x <= '0;
      freestream_y <= '0;
      scale_factor <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREESTREAM_X: freestream_x <= cfg_data;
        REG_FREESTREAM_Y: freestream_y <= cfg_data;
        REG_SCALE_FACTOR: scale_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  uas_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .w_center     (w_center),
    .w_left2      (w_left2),
    .w_left1      (w_left1),
    .w_right1     (w_right1),
    .w_right2     (w_right2),
    .w_down2      (w_down2),
    .w_down1      (w_down1),
    .w_up1        (w_up1),
    .w_up2        (w_up2),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .edge_case    (edge_case),
    .freestream_x (freestream_x),
    .freestream_y (freestream_y),
    .item_valid   (fq_valid),
    .item         (fq_item),
    .item_ready   (fq_ready)
  );

  uas_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_item)
  );

  uas_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (qb_valid),
    .item_ready   (qb_ready),
    .item         (qb_item),
    .scale_factor (scale_factor),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rhs_value    (rhs_value)
  );

endmodule

// ===== sv/uas_checker.sv =====
// Port-level checks for the upwind advection stencil, bound to the top level.
// Depends on uas_pkg and upwind_advection_stencil.
module uas_checker import uas_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] rhs_value
);

  // no result can appear in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // input stalls only when results are backed up at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result pending");

  // a pending result holds its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rhs_value))
    else $error("rhs_value changed while stalled");

endmodule

bind upwind_advection_stencil uas_checker u_uas_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .rhs_value (rhs_value)
);
